// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the page frame replacer.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/pprp_pkg.sv -----
// Shared types and constants of the pinned page frame replacer.
// Used by the controller, the datapath and the top level; depends on nothing.
package pprp_pkg;

	localparam int FUNC_W = 3;
	localparam int FILE_W = 16;
	localparam int PAGE_W = 48;
	localparam int SLOT_W = 4;

	// Request function codes
	localparam logic [FUNC_W-1:0] FUNC_FIX        = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_UNFIX      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH_FILE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_EVICT_FILE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH_ALL  = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture request, restart scan
		logic scan;    // examine one slot for fix or unfix
		logic commit;  // apply fix or unfix and emit its result
		logic flush;   // examine one slot for flush or evict
		logic fin;     // emit the closing result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic idx_last;   // scan index sits on the last slot
		logic need_emit;  // current slot produces a writeback result
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

// ----- rtl/pprp_ctrl.sv -----
// Sequencer of the page frame replacer: steps the slot scan and commits.
// Depends on pprp_pkg for command and status types and function codes.
module pprp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic [pprp_pkg::FUNC_W-1:0]    func,
	output logic                           req_ready,
	output pprp_pkg::cmd_t                 cmd,
	input  pprp_pkg::sts_t                 sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_FLUSH,
		ST_LAST
	} state_t;

	state_t state_q;
	logic   flush_go;

	// Hold off a flush step while its result has nowhere to go
	assign flush_go  = !(sts.need_emit && !sts.out_free);
	assign req_ready = (state_q == ST_IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && req_valid;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT) && sts.out_free;
		cmd.flush  = (state_q == ST_FLUSH) && flush_go;
		cmd.fin    = (state_q == ST_LAST) && sts.out_free;
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (func == pprp_pkg::FUNC_FIX || func == pprp_pkg::FUNC_UNFIX)
							state_q <= ST_SCAN;
						else if (func == pprp_pkg::FUNC_FLUSH_FILE ||
							 func == pprp_pkg::FUNC_EVICT_FILE ||
							 func == pprp_pkg::FUNC_FLUSH_ALL)
							state_q <= ST_FLUSH;
						else
							state_q <= ST_LAST;
					end
				end
				ST_SCAN: begin
					if (sts.idx_last) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (flush_go && sts.idx_last) state_q <= ST_LAST;
				end
				ST_LAST: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/pprp_datapath.sv -----
// Frame table, queue ranks, scan trackers and output register of the replacer.
// Depends on pprp_pkg; driven by commands from pprp_ctrl.
module pprp_datapath #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 48,
	parameter int PIN_BITS  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pprp_pkg::cmd_t                 cmd,
	output pprp_pkg::sts_t                 sts,
	input  logic [pprp_pkg::FUNC_W-1:0]    func,
	input  logic [pprp_pkg::FILE_W-1:0]    file_id,
	input  logic [pprp_pkg::PAGE_W-1:0]    page_id,
	input  logic                           dirty,
	input  logic                           rsp_ready,
	output logic                           rsp_valid,
	output logic [pprp_pkg::SLOT_W-1:0]    slot,
	output logic                           hit,
	output logic                           load_needed,
	output logic                           no_frame,
	output logic                           victim_valid,
	output logic                           writeback,
	output logic [pprp_pkg::FILE_W-1:0]    wb_file,
	output logic [pprp_pkg::PAGE_W-1:0]    wb_page,
	output logic                           last
);

	localparam int SW = $clog2(FRAMES);
	localparam int LW = $clog2(FRAMES + 1);
	localparam int FW = pprp_pkg::FILE_W;
	localparam logic [SW-1:0]       LAST_IDX = SW'(FRAMES - 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX  = '1;
	localparam logic [PIN_BITS-1:0] PIN_ONE  = PIN_BITS'(1);

	// Frame table, one lane per slot
	logic                 vld_q  [FRAMES];
	logic [FW-1:0]        tf_q   [FRAMES];
	logic [PAGE_BITS-1:0] tp_q   [FRAMES];
	logic [PIN_BITS-1:0]  pin_q  [FRAMES];
	logic                 dty_q  [FRAMES];
	logic                 lru_q  [FRAMES];
	logic [SW-1:0]        rank_q [FRAMES];
	logic [LW-1:0]        fifo_len_q, lru_len_q;

	// Captured request
	logic [pprp_pkg::FUNC_W-1:0] func_q;
	logic [FW-1:0]               file_q;
	logic [PAGE_BITS-1:0]        page_q;
	logic                        dt_q;

	// Scan trackers
	logic [SW-1:0]        idx_q;
	logic                 hit_found_q, free_found_q, fv_found_q, lv_found_q;
	logic [SW-1:0]        hit_slot_q, free_slot_q, fv_slot_q, lv_slot_q;
	logic [SW-1:0]        h_rank_q, fv_rank_q, lv_rank_q;
	logic                 h_lru_q;
	logic [PIN_BITS-1:0]  h_pin_q;
	logic [FW-1:0]        fv_tf_q, lv_tf_q;
	logic [PAGE_BITS-1:0] fv_tp_q, lv_tp_q;
	logic                 fv_dty_q, lv_dty_q;

	// Output register
	logic                      out_valid_q;
	logic [pprp_pkg::SLOT_W-1:0] o_slot_q;
	logic                      o_hit_q, o_load_q, o_nofr_q, o_vic_q, o_wb_q, o_last_q;
	logic [FW-1:0]             o_wf_q;
	logic [pprp_pkg::PAGE_W-1:0] o_wp_q;

	// Current lane under the scan index
	logic                 cur_vld, cur_dty, cur_lru;
	logic [FW-1:0]        cur_tf;
	logic [PAGE_BITS-1:0] cur_tp;
	logic [PIN_BITS-1:0]  cur_pin;
	logic [SW-1:0]        cur_rank;
	logic                 tag_eq, fifo_cand, lru_cand, concerned, need_emit;

	assign cur_vld  = vld_q[idx_q];
	assign cur_tf   = tf_q[idx_q];
	assign cur_tp   = tp_q[idx_q];
	assign cur_pin  = pin_q[idx_q];
	assign cur_dty  = dty_q[idx_q];
	assign cur_lru  = lru_q[idx_q];
	assign cur_rank = rank_q[idx_q];

	assign tag_eq    = cur_vld && (cur_tf == file_q) && (cur_tp == page_q);
	assign fifo_cand = cur_vld && (cur_pin == '0) && !cur_lru &&
			   (!fv_found_q || (cur_rank < fv_rank_q));
	assign lru_cand  = cur_vld && (cur_pin == '0) && cur_lru &&
			   (!lv_found_q || (cur_rank < lv_rank_q));
	assign concerned = cur_vld &&
			   ((func_q == pprp_pkg::FUNC_FLUSH_ALL) || (cur_tf == file_q));
	assign need_emit = concerned && cur_dty;

	assign sts.idx_last  = (idx_q == LAST_IDX);
	assign sts.need_emit = need_emit;
	assign sts.out_free  = !out_valid_q || rsp_ready;

	// Commit decode
	logic                 is_fix, vic_found, vic_lru, vic_dty;
	logic [SW-1:0]        vic_slot, vic_rank;
	logic [FW-1:0]        vic_tf;
	logic [PAGE_BITS-1:0] vic_tp;
	logic                 fix_hit, fix_free, fix_vic, unfix_hit, ev_drop, dirty_clr;
	logic                 new_frame;
	logic [SW-1:0]        new_slot;
	logic [LW-1:0]        hit_rank_w, vic_rank_w;

	assign is_fix    = (func_q == pprp_pkg::FUNC_FIX);
	assign vic_found = fv_found_q || lv_found_q;
	assign vic_lru   = !fv_found_q;
	assign vic_slot  = fv_found_q ? fv_slot_q : lv_slot_q;
	assign vic_rank  = fv_found_q ? fv_rank_q : lv_rank_q;
	assign vic_tf    = fv_found_q ? fv_tf_q : lv_tf_q;
	assign vic_tp    = fv_found_q ? fv_tp_q : lv_tp_q;
	assign vic_dty   = fv_found_q ? fv_dty_q : lv_dty_q;

	assign fix_hit   = cmd.commit && is_fix && hit_found_q;
	assign fix_free  = cmd.commit && is_fix && !hit_found_q && free_found_q;
	assign fix_vic   = cmd.commit && is_fix && !hit_found_q && !free_found_q && vic_found;
	assign unfix_hit = cmd.commit && !is_fix && hit_found_q;
	assign ev_drop   = cmd.flush && (func_q == pprp_pkg::FUNC_EVICT_FILE) && concerned;
	assign dirty_clr = cmd.flush && need_emit;
	assign new_frame = fix_free || fix_vic;
	assign new_slot  = fix_free ? free_slot_q : vic_slot;

	assign hit_rank_w = lru_len_q - LW'(h_lru_q);
	assign vic_rank_w = (fix_vic && !vic_lru) ? (fifo_len_q - LW'(1)) : fifo_len_q;

	// Queue removal: close the gap behind the removed rank
	logic          dec_en, dec_lru;
	logic [SW-1:0] dec_rank;

	always_comb begin
		dec_en   = 1'b0;
		dec_lru  = 1'b0;
		dec_rank = '0;
		priority if (fix_hit) begin
			dec_en   = 1'b1;
			dec_lru  = h_lru_q;
			dec_rank = h_rank_q;
		end else if (fix_vic) begin
			dec_en   = 1'b1;
			dec_lru  = vic_lru;
			dec_rank = vic_rank;
		end else if (ev_drop) begin
			dec_en   = 1'b1;
			dec_lru  = cur_lru;
			dec_rank = cur_rank;
		end
	end

	// Result selection
	logic                        emit;
	logic [SW-1:0]               e_slot;
	logic                        e_hit, e_load, e_nofr, e_vic, e_wb, e_last;
	logic [FW-1:0]               e_wf;
	logic [PAGE_BITS-1:0]        e_wp;

	assign emit = cmd.commit || dirty_clr || cmd.fin;

	always_comb begin
		e_slot = '0;
		e_hit  = 1'b0;
		e_load = 1'b0;
		e_nofr = 1'b0;
		e_vic  = 1'b0;
		e_wb   = 1'b0;
		e_wf   = '0;
		e_wp   = '0;
		e_last = 1'b1;
		priority if (cmd.commit) begin
			if (hit_found_q) begin
				e_slot = hit_slot_q;
				e_hit  = 1'b1;
			end else if (!is_fix) begin
				e_slot = '0;
			end else if (free_found_q) begin
				e_slot = free_slot_q;
				e_load = 1'b1;
			end else if (vic_found) begin
				e_slot = vic_slot;
				e_load = 1'b1;
				e_vic  = 1'b1;
				e_wb   = vic_dty;
				e_wf   = vic_tf;
				e_wp   = vic_tp;
			end else begin
				e_nofr = 1'b1;
			end
		end else if (cmd.flush) begin
			e_slot = idx_q;
			e_wb   = 1'b1;
			e_wf   = cur_tf;
			e_wp   = cur_tp;
			e_last = 1'b0;
		end
	end

	// Control state: valid bits, queue lengths, scan flags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FRAMES; j++) vld_q[j] <= 1'b0;
			fifo_len_q   <= '0;
			lru_len_q    <= '0;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			fv_found_q   <= 1'b0;
			lv_found_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				fv_found_q   <= 1'b0;
				lv_found_q   <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + SW'(1);
				if (tag_eq) hit_found_q <= 1'b1;
				if (!cur_vld) free_found_q <= 1'b1;
				if (fifo_cand) fv_found_q <= 1'b1;
				if (lru_cand) lv_found_q <= 1'b1;
			end
			if (cmd.flush) idx_q <= idx_q + SW'(1);
			if (new_frame) vld_q[new_slot] <= 1'b1;
			if (ev_drop) vld_q[idx_q] <= 1'b0;
			// Move frames between queues
			if (fix_hit && !h_lru_q) begin
				fifo_len_q <= fifo_len_q - LW'(1);
				lru_len_q  <= lru_len_q + LW'(1);
			end
			if (fix_free) fifo_len_q <= fifo_len_q + LW'(1);
			if (fix_vic && vic_lru) begin
				fifo_len_q <= fifo_len_q + LW'(1);
				lru_len_q  <= lru_len_q - LW'(1);
			end
			if (ev_drop) begin
				if (cur_lru) lru_len_q <= lru_len_q - LW'(1);
				else fifo_len_q <= fifo_len_q - LW'(1);
			end
			if (emit) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload: request capture, scan captures, frame fields, result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			file_q <= file_id;
			page_q <= page_id[PAGE_BITS-1:0];
			dt_q   <= dirty;
		end
		if (cmd.scan) begin
			if (tag_eq && !hit_found_q) begin
				hit_slot_q <= idx_q;
				h_rank_q   <= cur_rank;
				h_lru_q    <= cur_lru;
				h_pin_q    <= cur_pin;
			end
			if (!cur_vld && !free_found_q) free_slot_q <= idx_q;
			if (fifo_cand) begin
				fv_slot_q <= idx_q;
				fv_rank_q <= cur_rank;
				fv_tf_q   <= cur_tf;
				fv_tp_q   <= cur_tp;
				fv_dty_q  <= cur_dty;
			end
			if (lru_cand) begin
				lv_slot_q <= idx_q;
				lv_rank_q <= cur_rank;
				lv_tf_q   <= cur_tf;
				lv_tp_q   <= cur_tp;
				lv_dty_q  <= cur_dty;
			end
		end
		for (int j = 0; j < FRAMES; j++) begin
			if (dec_en && vld_q[j] && (lru_q[j] == dec_lru) && (rank_q[j] > dec_rank))
				rank_q[j] <= rank_q[j] - SW'(1);
		end
		if (fix_hit) begin
			lru_q[hit_slot_q]  <= 1'b1;
			rank_q[hit_slot_q] <= hit_rank_w[SW-1:0];
			if (h_pin_q != PIN_MAX) pin_q[hit_slot_q] <= h_pin_q + PIN_ONE;
		end
		if (new_frame) begin
			tf_q[new_slot]   <= file_q;
			tp_q[new_slot]   <= page_q;
			pin_q[new_slot]  <= PIN_ONE;
			dty_q[new_slot]  <= 1'b0;
			lru_q[new_slot]  <= 1'b0;
			rank_q[new_slot] <= vic_rank_w[SW-1:0];
		end
		if (unfix_hit) begin
			if (dt_q) dty_q[hit_slot_q] <= 1'b1;
			if (h_pin_q != '0) pin_q[hit_slot_q] <= h_pin_q - PIN_ONE;
		end
		if (dirty_clr) dty_q[idx_q] <= 1'b0;
		if (emit) begin
			o_slot_q <= pprp_pkg::SLOT_W'(e_slot);
			o_hit_q  <= e_hit;
			o_load_q <= e_load;
			o_nofr_q <= e_nofr;
			o_vic_q  <= e_vic;
			o_wb_q   <= e_wb;
			o_wf_q   <= e_wf;
			o_wp_q   <= pprp_pkg::PAGE_W'(e_wp);
			o_last_q <= e_last;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign slot         = o_slot_q;
	assign hit          = o_hit_q;
	assign load_needed  = o_load_q;
	assign no_frame     = o_nofr_q;
	assign victim_valid = o_vic_q;
	assign writeback    = o_wb_q;
	assign wb_file      = o_wf_q;
	assign wb_page      = o_wp_q;
	assign last         = o_last_q;

endmodule

// ----- rtl/pinned_page_frame_replacer_top.sv -----
// Top level of the pinned page frame replacer: sequencer plus frame datapath.
// Depends on pprp_pkg, pprp_ctrl, pprp_datapath and assert_macros.svh.

// Page frame table with pin counts and FIFO/LRU two-queue replacement. Fix,
// unfix, flush and evict requests scan the table one slot per clock while no
// flush step stalls. Fix and unfix run accept, a scan step for each slot and
// commit; flush and evict run accept, a slot step for each slot and a closing
// result; unknown codes go from accept straight to the closing result. Any
// step that has a result to send stalls while the output register still holds
// an untaken result. A finished result sits in an output register, so the
// next request is taken while it waits. Flush and evict send one writeback
// result per dirty frame of the file (of every file for flush all) in slot
// order and close with a result that carries only last. The exclusive
// request bit does not affect any result.
`include "assert_macros.svh"

module pinned_page_frame_replacer_top #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 48,
	parameter int PIN_BITS  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [pprp_pkg::FUNC_W-1:0]    func,
	input  logic [pprp_pkg::FILE_W-1:0]    file_id,
	input  logic [pprp_pkg::PAGE_W-1:0]    page_id,
	input  logic                           exclusive,
	input  logic                           dirty,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [pprp_pkg::SLOT_W-1:0]    slot,
	output logic                           hit,
	output logic                           load_needed,
	output logic                           no_frame,
	output logic                           victim_valid,
	output logic                           writeback,
	output logic [pprp_pkg::FILE_W-1:0]    wb_file,
	output logic [pprp_pkg::PAGE_W-1:0]    wb_page,
	output logic                           last
);

	pprp_pkg::cmd_t cmd;
	pprp_pkg::sts_t sts;

	// Sequencer
	pprp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.func      (func),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Frame table and result register
	pprp_datapath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.PIN_BITS  (PIN_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.file_id      (file_id),
		.page_id      (page_id),
		.dirty        (dirty),
		.rsp_ready    (rsp_ready),
		.rsp_valid    (rsp_valid),
		.slot         (slot),
		.hit          (hit),
		.load_needed  (load_needed),
		.no_frame     (no_frame),
		.victim_valid (victim_valid),
		.writeback    (writeback),
		.wb_file      (wb_file),
		.wb_page      (wb_page),
		.last         (last)
	);

	// Checks on the sequencing and the results
	`ASSERT_CLK(a_busy_after_transfer, clk, arst_n, req_valid && req_ready |=> !req_ready, "request taken while previous one in progress")
	`ASSERT_NEVER(a_step_while_ready, clk, arst_n, req_ready && (cmd.scan || cmd.flush || cmd.commit), "scan step while idle")
	`ASSERT_NEVER(a_hit_and_load, clk, arst_n, rsp_valid && hit && load_needed, "result is both hit and load")
	`ASSERT_CLK(a_noframe_alone, clk, arst_n, rsp_valid && no_frame |-> last && !load_needed && !victim_valid, "no frame result carries other flags")

endmodule
